### rtl/pm2_pkg.sv
// Shared types and constants for the 2-D prefix-max block.
// Used by pm2_front, pm2_queue, pm2_back and prefix_max_2d_unit.
`timescale 1ns / 1ps

package pm2_pkg;

  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int LEN_W    = COL_W + 1;
  localparam int DATA_W   = 32;
  localparam int Q_DEPTH  = 2;
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_COLS);

  // classified item handed from front to back
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [COL_W-1:0]         col;
    logic                     use_left;
    logic                     use_prev;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic              s2_valid;
    logic [QCNT_W-1:0] ob_count;
  } bk_stat_t;

endpackage

### rtl/pm2_front.sv
// Front end: takes input items, tracks row/column position, classifies each item.
// Depends on pm2_pkg.
`timescale 1ns / 1ps

module pm2_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic signed [pm2_pkg::DATA_W-1:0] value,
  input  logic                             frame_start,
  input  logic                             cfg_we,
  input  logic [pm2_pkg::LEN_W-1:0]        cfg_data,
  output pm2_pkg::item_t                   item
);

  logic [pm2_pkg::LEN_W-1:0] row_length;
  logic [pm2_pkg::LEN_W-1:0] len_eff;
  logic [pm2_pkg::COL_W-1:0] col;
  logic [pm2_pkg::COL_W-1:0] col_next;
  logic                      in_first_row;
  logic                      in_first_row_next;
  logic [pm2_pkg::COL_W-1:0] c;
  logic                      first;
  logic                      last;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= pm2_pkg::LEN_RESET;
    end else if (cfg_we) begin
      row_length <= cfg_data;
    end
  end

  // zero acts as one, anything past the line store acts as its size
  always_comb begin
    if (row_length == '0) begin
      len_eff = pm2_pkg::LEN_W'(1);
    end else if (row_length > pm2_pkg::LEN_W'(pm2_pkg::MAX_COLS)) begin
      len_eff = pm2_pkg::LEN_W'(pm2_pkg::MAX_COLS);
    end else begin
      len_eff = row_length;
    end
  end

  always_comb begin
    c     = frame_start ? '0 : col;
    first = frame_start ? 1'b1 : in_first_row;
    last  = ({1'b0, c} + pm2_pkg::LEN_W'(1)) >= len_eff;
    col_next          = last ? '0 : c + pm2_pkg::COL_W'(1);
    in_first_row_next = last ? 1'b0 : first;
    item.value    = value;
    item.col      = c;
    item.use_left = (c != '0);
    item.use_prev = !first;
    item.last     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      in_first_row <= 1'b1;
    end else if (accept) begin
      col          <= col_next;
      in_first_row <= in_first_row_next;
    end
  end

endmodule

### rtl/pm2_queue.sv
// Two-entry item queue between front and back ends.
// Depends on pm2_pkg.
`timescale 1ns / 1ps

module pm2_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pm2_pkg::item_t    push_item,
  input  logic              pop,
  output pm2_pkg::item_t    head,
  output pm2_pkg::q_stat_t  stat
);

  pm2_pkg::item_t                entries [pm2_pkg::Q_DEPTH];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [pm2_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == pm2_pkg::QCNT_W'(pm2_pkg::Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + pm2_pkg::QCNT_W'(1);
        2'b01:   count <= count - pm2_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/pm2_back.sv
// Back end: line-store read, max of element/left/above, line-store write, result buffer.
// Depends on pm2_pkg.
`timescale 1ns / 1ps

module pm2_back (
  input  logic                              clk,
  input  logic                              rst,
  input  pm2_pkg::item_t                    head,
  input  pm2_pkg::q_stat_t                  q_stat,
  output logic                              q_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [pm2_pkg::DATA_W-1:0] prefix_max,
  output logic                              row_end,
  output pm2_pkg::bk_stat_t                 stat
);

  logic signed [pm2_pkg::DATA_W-1:0] line_mem [pm2_pkg::MAX_COLS];
  logic signed [pm2_pkg::DATA_W-1:0] rd_data;
  logic signed [pm2_pkg::DATA_W-1:0] byp_val;
  logic                              byp;
  pm2_pkg::item_t                    s2_item;
  logic                              s2_valid;
  logic                              s2_fire;
  logic                              adv;
  logic                              take;
  logic signed [pm2_pkg::DATA_W-1:0] left_max;
  logic signed [pm2_pkg::DATA_W-1:0] prev;
  logic signed [pm2_pkg::DATA_W-1:0] m_left;
  logic signed [pm2_pkg::DATA_W-1:0] m;

  logic signed [pm2_pkg::DATA_W-1:0] ob_max  [pm2_pkg::Q_DEPTH];
  logic                              ob_last [pm2_pkg::Q_DEPTH];
  logic                              ob_wr;
  logic                              ob_rd;
  logic [pm2_pkg::QCNT_W-1:0]        ob_count;
  logic                              ob_pop;

  assign empty  = (ob_count == '0);
  assign ob_pop = pop && !empty;
  assign s2_fire = s2_valid &&
                   (ob_count != pm2_pkg::QCNT_W'(pm2_pkg::Q_DEPTH) || ob_pop);
  assign adv    = !s2_valid || s2_fire;
  assign take   = adv && !q_stat.empty;
  assign q_pop  = take;

  // the item leaving writes the same column the entering item reads: forward it
  always_comb begin
    prev   = byp ? byp_val : rd_data;
    m_left = (s2_item.use_left && left_max > s2_item.value) ? left_max : s2_item.value;
    m      = (s2_item.use_prev && prev > m_left) ? prev : m_left;
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      line_mem[s2_item.col] <= m;
    end
    if (take) begin
      rd_data <= line_mem[head.col];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_item <= head;
      byp_val <= m;
      byp     <= s2_fire && (s2_item.col == head.col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      left_max <= '0;
    end else begin
      if (adv) begin
        s2_valid <= !q_stat.empty;
      end
      if (s2_fire) begin
        left_max <= m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      ob_max[ob_wr]  <= m;
      ob_last[ob_wr] <= s2_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr    <= 1'b0;
      ob_rd    <= 1'b0;
      ob_count <= '0;
    end else begin
      if (s2_fire) begin
        ob_wr <= !ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= !ob_rd;
      end
      case ({s2_fire, ob_pop})
        2'b10:   ob_count <= ob_count + pm2_pkg::QCNT_W'(1);
        2'b01:   ob_count <= ob_count - pm2_pkg::QCNT_W'(1);
        default: ob_count <= ob_count;
      endcase
    end
  end

  assign prefix_max     = ob_max[ob_rd];
  assign row_end        = ob_last[ob_rd];
  assign stat.s2_valid  = s2_valid;
  assign stat.ob_count  = ob_count;

endmodule

### rtl/prefix_max_2d_unit.sv
// Top level of the 2-D prefix-max block: front end, item queue, back end.
// Depends on pm2_pkg, pm2_front, pm2_queue, pm2_back.
//
//   channel  | handshake      | payload
//   ---------+----------------+---------------------------
//   input    | push / full    | value[31:0], frame_start
//   result   | pop / empty    | prefix_max[31:0], row_end
//   config   | cfg_we         | cfg_data[10:0] (row length)
//
// One item per cycle sustained while results are popped. The back end reads the line
// store in the stage ahead of the max/write stage; a same-column write in the cycle of
// the read is forwarded. Reset (rst, synchronous) empties both queues and restarts at
// row 0, column 0; row length returns to 1024. Full rises only when the result side
// stalls long enough to fill the 2-entry item queue and 2-entry result buffer.
`timescale 1ns / 1ps

module prefix_max_2d_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [pm2_pkg::DATA_W-1:0] value,
  input  logic                              frame_start,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [pm2_pkg::DATA_W-1:0] prefix_max,
  output logic                              row_end,
  input  logic                              cfg_we,
  input  logic [pm2_pkg::LEN_W-1:0]         cfg_data
);

  pm2_pkg::item_t    f_item;
  pm2_pkg::item_t    q_head;
  pm2_pkg::q_stat_t  q_stat;
  pm2_pkg::bk_stat_t b_stat;
  logic              accept;
  logic              q_pop;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  pm2_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .value       (value),
    .frame_start (frame_start),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .item        (f_item)
  );

  pm2_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (f_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  pm2_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .prefix_max (prefix_max),
    .row_end    (row_end),
    .stat       (b_stat)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full && !b_stat.s2_valid))
    else $error("reset did not clear queues");

  a_q_sane: assert property (@(posedge clk) disable iff (rst) !(q_stat.full && q_stat.empty))
    else $error("item queue both full and empty");

  a_ob_bound: assert property (@(posedge clk) disable iff (rst)
      b_stat.ob_count <= pm2_pkg::QCNT_W'(pm2_pkg::Q_DEPTH))
    else $error("result buffer overflow");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
      empty == (b_stat.ob_count == '0))
    else $error("empty disagrees with result buffer count");

endmodule
